// File: src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; spq_cell and the top level import this package.
package spq_pkg;

	// Widths of the fixed payload fields.
	localparam int FIELD_W  = 16;
	localparam int OCC_W    = 5;
	localparam int STATUS_W = 2;

	// Defaults for the top-level parameters.
	localparam int DEPTH_DEF     = 16;
	localparam int KEY_BITS_DEF  = 16;
	localparam int PRIO_BITS_DEF = 16;

	typedef enum logic [0:0] {
		CMD_INSERT = 1'b0,
		CMD_POP    = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED     = 2'd0,
		ST_UPDATED   = 2'd1,
		ST_DISCARDED = 2'd2,
		ST_EVICTED   = 2'd3
	} status_t;

	// Control broadcast from the sequencer to every cell of the chain.
	typedef struct packed {
		logic load;   // latch compare flags against the incoming word
		logic write;  // commit an insert or key update
		logic pop;    // shift the whole chain toward the head
	} cell_ctl_t;

endpackage

// File: src/spq_cell.sv
// One cell of the sorted queue chain: holds one entry and its compare flags.
// Depends on spq_pkg for the control struct and the field width.
module spq_cell #(
	parameter int IDX   = 0,
	parameter int DEPTH = 16,
	parameter int KW    = 16,
	parameter int PW    = 16,
	localparam int IW   = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  spq_pkg::cell_ctl_t         ctl,
	input  logic                       occupied,
	input  logic [IW-1:0]              limit,
	input  logic [KW-1:0]              cmp_key,
	input  logic [PW-1:0]              cmp_prio,
	input  logic [KW-1:0]              new_key,
	input  logic [spq_pkg::FIELD_W-1:0] new_cost,
	input  logic [PW-1:0]              new_prio,
	input  logic                       lo_gt,
	input  logic [KW-1:0]              lo_key,
	input  logic [spq_pkg::FIELD_W-1:0] lo_cost,
	input  logic [PW-1:0]              lo_prio,
	input  logic [KW-1:0]              hi_key,
	input  logic [spq_pkg::FIELD_W-1:0] hi_cost,
	input  logic [PW-1:0]              hi_prio,
	output logic [KW-1:0]              key,
	output logic [spq_pkg::FIELD_W-1:0] cost,
	output logic [PW-1:0]              prio,
	output logic                       gt,
	output logic                       match
);
	import spq_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [KW-1:0]      key_q;
	logic [FIELD_W-1:0] cost_q;
	logic [PW-1:0]      prio_q;
	logic               gt_q;
	logic               match_q;
	logic               in_range;

	assign in_range = (MY_IDX <= limit);

	// The flags see the word at acceptance; the chain update follows at its commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q    <= 1'b0;
			match_q <= 1'b0;
		end else if (ctl.load) begin
			gt_q    <= occupied && (cmp_prio < prio_q);
			match_q <= occupied && (cmp_key == key_q);
		end
	end

	// An insert slides larger entries back by one and drops the word into the gap.
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			key_q  <= hi_key;
			cost_q <= hi_cost;
			prio_q <= hi_prio;
		end else if (ctl.write && in_range) begin
			if (lo_gt) begin
				key_q  <= lo_key;
				cost_q <= lo_cost;
				prio_q <= lo_prio;
			end else if (gt_q || (MY_IDX == limit)) begin
				key_q  <= new_key;
				cost_q <= new_cost;
				prio_q <= new_prio;
			end
		end
	end

	assign key   = key_q;
	assign cost  = cost_q;
	assign prio  = prio_q;
	assign gt    = gt_q;
	assign match = match_q;

endmodule

// File: src/spq_locate.sv
// Encodes the one-hot key match flags of the chain into a cell index.
// Depends on nothing beyond its parameters; spq_pkg is not needed here.
module spq_locate #(
	parameter int DEPTH = 16,
	localparam int IW   = $clog2(DEPTH)
) (
	input  logic [DEPTH-1:0] match_vec,
	output logic             any,
	output logic [IW-1:0]    idx
);

	assign any = |match_vec;

	// Keys in the queue are unique, so at most one flag is set and an OR per bit suffices.
	always_comb begin
		idx = '0;
		for (int j = 0; j < DEPTH; j++) begin
			for (int b = 0; b < IW; b++) begin
				if (j[b]) begin
					idx[b] = idx[b] | match_vec[j];
				end
			end
		end
	end

endmodule

// File: src/sorted_priority_queue_with_key_update.sv
// Top level of the bounded sorted priority queue with key update.
// Depends on spq_pkg, spq_cell and spq_locate.
//
//   channel | direction | handshake           | fields
//   --------+-----------+---------------------+--------------------------------------------
//   in      | input     | in_valid / in_stall | command, item_key, item_cost, item_priority
//   out     | output    | out_valid/out_stall | popped_valid, popped_key, popped_cost,
//           |           |                     | popped_priority, insert_status, occupancy
//
// Each word is accepted, then committed: the acceptance edge latches the word and
// the compare flags of every cell, and the commit edge updates the chain and loads
// the result. A new word is taken only after the commit of the last one.
// Reset clears the fill count and the control flags; entry storage holds no reset.
// One result register parts the sides: a word is accepted while a result waits, and
// its commit waits until that result has been taken.
module sorted_priority_queue_with_key_update #(
	parameter int DEPTH     = spq_pkg::DEPTH_DEF,
	parameter int KEY_BITS  = spq_pkg::KEY_BITS_DEF,
	parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [spq_pkg::FIELD_W-1:0]   item_key,
	input  logic [spq_pkg::FIELD_W-1:0]   item_cost,
	input  logic [spq_pkg::FIELD_W-1:0]   item_priority,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          popped_valid,
	output logic [spq_pkg::FIELD_W-1:0]   popped_key,
	output logic [spq_pkg::FIELD_W-1:0]   popped_cost,
	output logic [spq_pkg::FIELD_W-1:0]   popped_priority,
	output logic [spq_pkg::STATUS_W-1:0]  insert_status,
	output logic [spq_pkg::OCC_W-1:0]     occupancy
);
	import spq_pkg::*;

	// Only the low KEY_BITS / PRIO_BITS of the 16-bit fields take part, so
	// storage is no wider than the field itself.
	localparam int KW = (KEY_BITS  < FIELD_W) ? KEY_BITS  : FIELD_W;
	localparam int PW = (PRIO_BITS < FIELD_W) ? PRIO_BITS : FIELD_W;
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
	localparam logic [IW-1:0] TAIL_IDX   = IW'(DEPTH - 1);

	// Word latched at acceptance and held through its commit.
	cmd_t               cmd_s1;
	logic [KW-1:0]      key_s1;
	logic [FIELD_W-1:0] cost_s1;
	logic [PW-1:0]      prio_s1;
	logic               busy_q;

	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      fill_d;

	// Result register.
	logic               out_valid_q;
	logic               popped_valid_q;
	logic [FIELD_W-1:0] popped_key_q;
	logic [FIELD_W-1:0] popped_cost_q;
	logic [FIELD_W-1:0] popped_priority_q;
	status_t            status_q;
	logic [OCC_W-1:0]   occupancy_q;

	// Chain taps.
	logic [KW-1:0]      key_v  [DEPTH];
	logic [FIELD_W-1:0] cost_v [DEPTH];
	logic [PW-1:0]      prio_v [DEPTH];
	logic [DEPTH-1:0]   gt_v;
	logic [DEPTH-1:0]   match_v;
	logic [DEPTH-1:0]   occ_v;

	logic               accept;
	logic               fire;
	logic               any_match;
	logic [IW-1:0]      match_idx;
	logic               improves;
	logic               full;
	cell_ctl_t          ctl_c;
	logic [IW-1:0]      limit_c;
	status_t            status_c;
	logic               pop_hit_c;

	assign accept   = in_valid && !in_stall;
	assign in_stall = busy_q;
	// The commit needs the result register free, or freed in this same cycle.
	assign fire     = busy_q && (!out_valid_q || !out_stall);
	assign full     = (fill_q == FULL_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fill_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_t'(command);
			key_s1  <= item_key[KW-1:0];
			cost_s1 <= item_cost;
			prio_s1 <= item_priority[PW-1:0];
		end
	end

	// A cell holds a live entry when its index is below the fill count.
	for (genvar i = 0; i < DEPTH; i++) begin : g_occ
		assign occ_v[i] = (CW'(i) < fill_q);
	end

	// The chain: each cell reads its lower neighbor for inserts and its upper
	// neighbor for pops. The head has no lower neighbor and the tail no upper one.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic               lo_gt;
		logic [KW-1:0]      lo_key;
		logic [FIELD_W-1:0] lo_cost;
		logic [PW-1:0]      lo_prio;
		logic [KW-1:0]      hi_key;
		logic [FIELD_W-1:0] hi_cost;
		logic [PW-1:0]      hi_prio;

		if (i > 0) begin : g_lo
			assign lo_gt   = gt_v[i-1];
			assign lo_key  = key_v[i-1];
			assign lo_cost = cost_v[i-1];
			assign lo_prio = prio_v[i-1];
		end else begin : g_head
			assign lo_gt   = 1'b0;
			assign lo_key  = '0;
			assign lo_cost = '0;
			assign lo_prio = '0;
		end

		if (i < DEPTH - 1) begin : g_hi
			assign hi_key  = key_v[i+1];
			assign hi_cost = cost_v[i+1];
			assign hi_prio = prio_v[i+1];
		end else begin : g_tail
			assign hi_key  = '0;
			assign hi_cost = '0;
			assign hi_prio = '0;
		end

		spq_cell #(
			.IDX   (i),
			.DEPTH (DEPTH),
			.KW    (KW),
			.PW    (PW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl_c),
			.occupied (occ_v[i]),
			.limit    (limit_c),
			.cmp_key  (item_key[KW-1:0]),
			.cmp_prio (item_priority[PW-1:0]),
			.new_key  (key_s1),
			.new_cost (cost_s1),
			.new_prio (prio_s1),
			.lo_gt    (lo_gt),
			.lo_key   (lo_key),
			.lo_cost  (lo_cost),
			.lo_prio  (lo_prio),
			.hi_key   (hi_key),
			.hi_cost  (hi_cost),
			.hi_prio  (hi_prio),
			.key      (key_v[i]),
			.cost     (cost_v[i]),
			.prio     (prio_v[i]),
			.gt       (gt_v[i]),
			.match    (match_v[i])
		);
	end

	spq_locate #(
		.DEPTH (DEPTH)
	) u_locate (
		.match_vec (match_v),
		.any       (any_match),
		.idx       (match_idx)
	);

	// The queued entry with the same key is replaced only when the new priority
	// is strictly smaller, which is exactly that cell's gt flag.
	assign improves = |(match_v & gt_v);

	// Sequencer: decides the commit for the held word. The limit is the last
	// cell that may change; cells from the sorted slot up to it shift back by one.
	always_comb begin
		ctl_c      = '0;
		ctl_c.load = accept;
		limit_c    = '0;
		fill_d     = fill_q;
		status_c   = ST_ADDED;
		pop_hit_c  = 1'b0;
		if (fire) begin
			if (cmd_s1 == CMD_POP) begin
				if (fill_q != '0) begin
					ctl_c.pop = 1'b1;
					pop_hit_c = 1'b1;
					fill_d    = fill_q - CW'(1);
				end
			end else if (any_match) begin
				if (improves) begin
					ctl_c.write = 1'b1;
					limit_c     = match_idx;
					status_c    = ST_UPDATED;
				end else begin
					status_c = ST_DISCARDED;
				end
			end else if (full) begin
				// The tail entry is overwritten, by a shifted entry or by the word itself.
				ctl_c.write = 1'b1;
				limit_c     = TAIL_IDX;
				status_c    = ST_EVICTED;
			end else begin
				ctl_c.write = 1'b1;
				limit_c     = fill_q[IW-1:0];
				fill_d      = fill_q + CW'(1);
				status_c    = ST_ADDED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// The head is read before the pop shifts it away, in the same edge.
	always_ff @(posedge clk) begin
		if (fire) begin
			popped_valid_q    <= pop_hit_c;
			popped_key_q      <= pop_hit_c ? FIELD_W'(key_v[0])  : '0;
			popped_cost_q     <= pop_hit_c ? cost_v[0]           : '0;
			popped_priority_q <= pop_hit_c ? FIELD_W'(prio_v[0]) : '0;
			status_q          <= status_c;
			occupancy_q       <= OCC_W'(fill_d);
		end
	end

	assign out_valid       = out_valid_q;
	assign popped_valid    = popped_valid_q;
	assign popped_key      = popped_key_q;
	assign popped_cost     = popped_cost_q;
	assign popped_priority = popped_priority_q;
	assign insert_status   = status_q;
	assign occupancy       = occupancy_q;

`ifndef SYNTHESIS
	a_fill_bound : assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_COUNT)
		else $error("fill count exceeds queue depth");

	a_busy_after_accept : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("accepted word not held for commit");

	a_unique_key : assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(match_v))
		else $error("more than one cell holds the same key");

	a_pop_status : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && popped_valid) |-> (insert_status == ST_ADDED))
		else $error("popped word carries an insert status");

	a_empty_pop : assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (cmd_s1 == CMD_POP) && (fill_q == '0)) |=>
		(!popped_valid && (occupancy == '0)))
		else $error("pop on empty queue returned an entry");
`endif

endmodule

// File: bench/spq_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the sorted priority queue bench: a model of the entry chain and
// the queue of outcomes that it predicts for each accepted word. Depends on spq_pkg.
package spq_scoreboard_pkg;
	import spq_pkg::*;

	typedef struct packed {
		logic                popped_valid;
		logic [FIELD_W-1:0]  popped_key;
		logic [FIELD_W-1:0]  popped_cost;
		logic [FIELD_W-1:0]  popped_priority;
		status_t             insert_status;
		logic [OCC_W-1:0]    occupancy;
	} outcome_t;

	class spq_scoreboard;
		logic [FIELD_W-1:0] slot_key  [DEPTH_DEF];
		logic [FIELD_W-1:0] slot_cost [DEPTH_DEF];
		logic [FIELD_W-1:0] slot_prio [DEPTH_DEF];
		int                 fill;
		outcome_t           queue_outcomes [$];
		int unsigned        mismatch_count;

		function new();
			fill = 0;
			mismatch_count = 0;
		endfunction

		function int pending();
			return queue_outcomes.size();
		endfunction

		// Slides entries back while the one in front has a larger priority, so an
		// entry lands behind everything of equal priority.
		function void settle(int pos, logic [FIELD_W-1:0] key, logic [FIELD_W-1:0] cost,
				logic [FIELD_W-1:0] prio);
			while (pos > 0 && prio < slot_prio[pos-1]) begin
				slot_key[pos]  = slot_key[pos-1];
				slot_cost[pos] = slot_cost[pos-1];
				slot_prio[pos] = slot_prio[pos-1];
				pos--;
			end
			slot_key[pos]  = key;
			slot_cost[pos] = cost;
			slot_prio[pos] = prio;
		endfunction

		function status_t insert_entry(logic [FIELD_W-1:0] key, logic [FIELD_W-1:0] cost,
				logic [FIELD_W-1:0] prio);
			int i;
			for (i = 0; i < fill; i++) begin
				if (slot_key[i] == key) begin
					if (prio < slot_prio[i]) begin
						settle(i, key, cost, prio);
						return ST_UPDATED;
					end
					return ST_DISCARDED;
				end
			end
			if (fill < DEPTH_DEF) begin
				fill++;
				settle(fill - 1, key, cost, prio);
				return ST_ADDED;
			end
			// Full: the tail slot is overwritten, then the new entry moves forward.
			settle(DEPTH_DEF - 1, key, cost, prio);
			return ST_EVICTED;
		endfunction

		function void note_command(cmd_t cmd, logic [FIELD_W-1:0] key,
				logic [FIELD_W-1:0] cost, logic [FIELD_W-1:0] prio);
			outcome_t o;
			int i;
			o = '0;
			if (cmd == CMD_INSERT) begin
				o.insert_status = insert_entry(key, cost, prio);
			end else if (fill > 0) begin
				o.popped_valid    = 1'b1;
				o.popped_key      = slot_key[0];
				o.popped_cost     = slot_cost[0];
				o.popped_priority = slot_prio[0];
				for (i = 0; i + 1 < fill; i++) begin
					slot_key[i]  = slot_key[i+1];
					slot_cost[i] = slot_cost[i+1];
					slot_prio[i] = slot_prio[i+1];
				end
				fill--;
			end
			o.occupancy = fill[OCC_W-1:0];
			queue_outcomes.push_back(o);
		endfunction

		function void compare_field(string name, logic [FIELD_W-1:0] want,
				logic [FIELD_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				mismatch_count++;
			end
		endfunction

		function void check_outcome(logic pv, logic [FIELD_W-1:0] pk, logic [FIELD_W-1:0] pc,
				logic [FIELD_W-1:0] pp, logic [STATUS_W-1:0] st, logic [OCC_W-1:0] occ);
			outcome_t o;
			if (queue_outcomes.size() == 0) begin
				$error("result word arrived with no outstanding command");
				mismatch_count++;
				return;
			end
			o = queue_outcomes.pop_front();
			compare_field("popped_valid", FIELD_W'(o.popped_valid), FIELD_W'(pv));
			compare_field("popped_key", o.popped_key, pk);
			compare_field("popped_cost", o.popped_cost, pc);
			compare_field("popped_priority", o.popped_priority, pp);
			compare_field("insert_status", FIELD_W'(o.insert_status), FIELD_W'(st));
			compare_field("occupancy", FIELD_W'(o.occupancy), FIELD_W'(occ));
		endfunction
	endclass

endpackage

// File: bench/sorted_priority_queue_with_key_update_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for sorted_priority_queue_with_key_update: directed and random
// insert/pop words against a scoreboard model. Depends on spq_pkg and spq_scoreboard_pkg.
module sorted_priority_queue_with_key_update_tb;
	import spq_pkg::*;
	import spq_scoreboard_pkg::*;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	cmd_t                command = CMD_INSERT;
	logic [FIELD_W-1:0]  item_key = '0;
	logic [FIELD_W-1:0]  item_cost = '0;
	logic [FIELD_W-1:0]  item_priority = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                popped_valid;
	logic [FIELD_W-1:0]  popped_key;
	logic [FIELD_W-1:0]  popped_cost;
	logic [FIELD_W-1:0]  popped_priority;
	logic [STATUS_W-1:0] insert_status;
	logic [OCC_W-1:0]    occupancy;

	// While this is set, neither side idles; it covers one long stretch of the run.
	bit steady = 1'b0;

	spq_scoreboard sb = new();

	sorted_priority_queue_with_key_update dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.item_key        (item_key),
		.item_cost       (item_cost),
		.item_priority   (item_priority),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.popped_valid    (popped_valid),
		.popped_key      (popped_key),
		.popped_cost     (popped_cost),
		.popped_priority (popped_priority),
		.insert_status   (insert_status),
		.occupancy       (occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiving side stalls with a chance of 37 in a hundred outside the steady
	// stretch. The stall changes only at falling edges, so it is stable at each rising edge.
	always @(negedge clk) begin
		out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 37);
	end

	// Every result word taken at a rising edge is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_outcome(popped_valid, popped_key, popped_cost, popped_priority,
				insert_status, occupancy);
		end
	end

	// Presents one word from a falling edge, holds it until the block accepts it, and
	// records it in the scoreboard at the acceptance edge. It returns at the falling
	// edge after acceptance, so valid stays high when the next word follows directly.
	task automatic issue_word(cmd_t cmd, logic [FIELD_W-1:0] key, logic [FIELD_W-1:0] cost,
			logic [FIELD_W-1:0] prio);
		while (!steady && $urandom_range(0, 99) < 37) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		item_key      <= key;
		item_cost     <= cost;
		item_priority <= prio;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_command(cmd, key, cost, prio);
		@(negedge clk);
	endtask

	task automatic pop_head();
		issue_word(CMD_POP, FIELD_W'($urandom()), FIELD_W'($urandom()), FIELD_W'($urandom()));
	endtask

	// Keys come mostly from a small pool, so duplicates are common while the pool still
	// holds more than DEPTH distinct keys; the rest span the whole field.
	function automatic logic [FIELD_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 85) return FIELD_W'($urandom_range(0, 23));
		return FIELD_W'($urandom());
	endfunction

	// Narrow priorities give many ties; wide ones exercise the full compare.
	function automatic logic [FIELD_W-1:0] pick_priority();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return FIELD_W'($urandom_range(0, 15));
		if (roll < 85) return FIELD_W'($urandom_range(0, 255));
		return FIELD_W'($urandom());
	endfunction

	task automatic run_random(int count);
		int n;
		int pop_pct;
		pop_pct = 50;
		for (n = 0; n < count; n++) begin
			// Every hundred words the mix swings between filling, balance and draining,
			// so the queue visits both empty and full with eviction in between.
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: begin
						pop_pct = 15;
					end
					1: begin
						pop_pct = 50;
					end
					default: begin
						pop_pct = 75;
					end
				endcase
			end
			steady = (n >= 700 && n < 1000);
			if ($urandom_range(0, 99) < pop_pct) begin
				pop_head();
			end else begin
				issue_word(CMD_INSERT, pick_key(), FIELD_W'($urandom()), pick_priority());
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening: a pop on the empty queue, field extremes, a key update,
		// a duplicate discarded at equal and at larger priority, and a new key that
		// ties an existing priority and must queue behind it.
		pop_head();
		issue_word(CMD_INSERT, 16'h0000, 16'h0000, 16'hFFFF);
		issue_word(CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'h0000);
		issue_word(CMD_INSERT, 16'hFFFF, 16'h1234, 16'h0000);
		issue_word(CMD_INSERT, 16'h0000, 16'hAAAA, 16'h8000);
		issue_word(CMD_INSERT, 16'h0000, 16'h5555, 16'h9000);
		issue_word(CMD_INSERT, 16'h0005, 16'h00FF, 16'h8000);
		issue_word(CMD_INSERT, 16'h0006, 16'hFF00, 16'h7FFF);
		pop_head();
		pop_head();
		pop_head();
		pop_head();
		pop_head();

		run_random(1537);
		in_valid <= 1'b0;

		// Drain what is still outstanding, then keep watching the result side, so that
		// any stray result word would show up as unexpected.
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest plausible run of about 1550 words with idling
	// on both sides.
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
